[design/rasc_pkg.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared codes and state types for the rational add, subtract and compare unit.
// ----------------------------------------------------------------------------
package rasc_pkg;

  localparam logic [1:0] MODE_REDUCE  = 2'd0;
  localparam logic [1:0] MODE_ADD     = 2'd1;
  localparam logic [1:0] MODE_SUB     = 2'd2;
  localparam logic [1:0] MODE_COMPARE = 2'd3;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_ZERO_DEN = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_RSTART = 15'b000000000000010,
    S_GCHK   = 15'b000000000000100,
    S_GDIV   = 15'b000000000001000,
    S_RDIVM  = 15'b000000000010000,
    S_RDIVD  = 15'b000000000100000,
    S_RET    = 15'b000000001000000,
    S_LD1    = 15'b000000010000000,
    S_LD2    = 15'b000000100000000,
    S_M1     = 15'b000001000000000,
    S_M2     = 15'b000010000000000,
    S_M3     = 15'b000100000000000,
    S_SUM    = 15'b001000000000000,
    S_FIN    = 15'b010000000000000,
    S_DONE   = 15'b100000000000000
  } state_t;

  typedef enum logic [3:0] {
    PH_A   = 4'b0001,
    PH_B   = 4'b0010,
    PH_LCM = 4'b0100,
    PH_RES = 4'b1000
  } phase_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } q_ctl_t;

endpackage

[design/rasc_div.sv]
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider giving quotient and remainder, one bit per cycle.
// ----------------------------------------------------------------------------
module rasc_div #(
  parameter int WW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [WW-1:0] num,
  input  logic [WW-1:0] den,
  output logic          done,
  output logic [WW-1:0] quo,
  output logic [WW-1:0] rem
);

  localparam int CW = $clog2(WW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [WW-1:0] dreg;
  logic [WW:0]   trial;
  logic [WW:0]   diff;

  assign trial = {rem, quo[WW-1]};
  assign diff  = trial - {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(WW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= num;
      dreg <= den;
    end else if (busy) begin
      if (!diff[WW]) begin
        rem <= diff[WW-1:0];
        quo <= {quo[WW-2:0], 1'b1};
      end else begin
        rem <= trial[WW-1:0];
        quo <= {quo[WW-2:0], 1'b0};
      end
    end
  end

endmodule

[design/rasc_front.sv]
// ----------------------------------------------------------------------------
// Front end
// Accepts items, splits sign and magnitude, flags zero denominators and
// holds classified items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rasc_front #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          mode,
  input  logic signed [31:0]  a_num,
  input  logic signed [31:0]  a_den,
  input  logic signed [31:0]  b_num,
  input  logic signed [31:0]  b_den,
  output rasc_pkg::q_ctl_t    q_ctl,
  input  logic                q_pop,
  output logic [1:0]          f_mode,
  output logic                f_zerr,
  output logic                f_aneg,
  output logic [W-1:0]        f_anum,
  output logic [W-1:0]        f_aden,
  output logic                f_bneg,
  output logic [W-1:0]        f_bnum,
  output logic [W-1:0]        f_bden
);
  import rasc_pkg::*;

  localparam int EW = 5 + 4 * W;

  logic [EW-1:0] mem [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;
  logic [EW-1:0] entry;
  logic [EW-1:0] head;
  logic          an_neg, ad_neg, bn_neg, bd_neg;
  logic [W-1:0]  an_mag, ad_mag, bn_mag, bd_mag;
  logic          zerr;

  function automatic logic [W:0] split(input logic [31:0] x);
    logic [W-1:0] v;
    v = x[W-1:0];
    if (v[W-1]) begin
      split = {1'b1, (~v) + 1'b1};
    end else begin
      split = {1'b0, v};
    end
  endfunction

  assign {an_neg, an_mag} = split(a_num);
  assign {ad_neg, ad_mag} = split(a_den);
  assign {bn_neg, bn_mag} = split(b_num);
  assign {bd_neg, bd_mag} = split(b_den);

  assign zerr = (a_den[W-1:0] == '0) || ((mode != MODE_REDUCE) && (b_den[W-1:0] == '0));

  assign entry = {mode, zerr, an_neg ^ ad_neg, an_mag, ad_mag, bn_neg ^ bd_neg, bn_mag, bd_mag};

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= entry;
    end
  end

  assign head        = mem[rptr];
  assign q_ctl.valid = (count != 2'd0);
  assign q_ctl.pop   = pop;
  assign {f_mode, f_zerr, f_aneg, f_anum, f_aden, f_bneg, f_bnum, f_bden} = head;

endmodule

[design/rasc_back.sv]
// ----------------------------------------------------------------------------
// Back end
// Sequencer that reduces operands by Euclid's algorithm, forms sums over the
// least common multiple, compares operands and drives the output register.
// ----------------------------------------------------------------------------
module rasc_back #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  rasc_pkg::q_ctl_t    q_ctl,
  output logic                q_pop,
  input  logic [1:0]          f_mode,
  input  logic                f_zerr,
  input  logic                f_aneg,
  input  logic [W-1:0]        f_anum,
  input  logic [W-1:0]        f_aden,
  input  logic                f_bneg,
  input  logic [W-1:0]        f_bnum,
  input  logic [W-1:0]        f_bden,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  res_num,
  output logic [30:0]         res_den,
  output logic                is_equal,
  output logic [1:0]          error_code
);
  import rasc_pkg::*;

  localparam int WW = 2 * W;
  localparam logic [WW-1:0] LIM = {{W{1'b0}}, 1'b1, {(W - 1){1'b0}}};

  state_t        state;
  phase_t        phase;
  logic [1:0]    mode_r;
  logic          p_neg;
  logic [WW-1:0] p_mag, p_den, x, y, g;
  logic          a_neg, b_neg, bi_neg;
  logic [W-1:0]  a_mag, a_den, b_mag, b_den, bi_num, bi_den;
  logic [W-1:0]  qa, qb;
  logic [WW-1:0] lcm, ma, mb;
  logic [W-1:0]  mul_a, mul_b;
  logic [WW-1:0] mul_p;
  logic          dv_start;
  logic [WW-1:0] dv_num, dv_den;
  logic          dv_done;
  logic [WW-1:0] dv_quo, dv_rem;
  logic signed [31:0] h_num;
  logic [30:0]   h_den;
  logic          h_eq;
  logic [1:0]    h_err;
  logic [WW-1:0] sn;
  logic          ovf;
  logic          nb_neg;

  rasc_div #(.WW(WW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (dv_quo),
    .rem   (dv_rem)
  );

  always_comb begin
    mul_a = qa;
    mul_b = b_den;
    case (state)
      S_M2: begin
        mul_a = a_mag;
        mul_b = qb;
      end
      S_M3: begin
        mul_a = b_mag;
        mul_b = qa;
      end
      default: begin
        mul_a = qa;
        mul_b = b_den;
      end
    endcase
  end

  assign mul_p  = WW'(mul_a) * WW'(mul_b);
  assign sn     = p_neg ? (~p_mag + 1'b1) : p_mag;
  assign ovf    = (p_den > LIM - 1'b1) || (p_neg ? (p_mag > LIM) : (p_mag > LIM - 1'b1));
  assign nb_neg = ((mode_r == MODE_SUB) && (p_mag != '0)) ? ~p_neg : p_neg;
  assign q_pop  = (state == S_IDLE) && q_ctl.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_start <= 1'b0;
    end else begin
      dv_start <= (state == S_GCHK) ||
                  (dv_done && ((state == S_RDIVM) || (state == S_LD1)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_A;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_ctl.valid) begin
            phase <= PH_A;
            if (f_zerr) begin
              state <= S_DONE;
            end else begin
              state <= S_RSTART;
            end
          end
        end
        S_RSTART: begin
          if (p_mag == '0) begin
            state <= S_RET;
          end else begin
            state <= S_GCHK;
          end
        end
        S_GCHK: begin
          if (y == '0) begin
            state <= (phase == PH_LCM) ? S_LD1 : S_RDIVM;
          end else begin
            state <= S_GDIV;
          end
        end
        S_GDIV: begin
          if (dv_done) begin
            state <= S_GCHK;
          end
        end
        S_RDIVM: begin
          if (dv_done) begin
            state    <= S_RDIVD;
          end
        end
        S_RDIVD: begin
          if (dv_done) begin
            state <= S_RET;
          end
        end
        S_RET: begin
          unique case (phase)
            PH_A: begin
              if (mode_r == MODE_REDUCE) begin
                state <= S_FIN;
              end else begin
                phase <= PH_B;
                state <= S_RSTART;
              end
            end
            PH_B: begin
              if (mode_r == MODE_COMPARE) begin
                state <= S_DONE;
              end else begin
                phase <= PH_LCM;
                state <= S_GCHK;
              end
            end
            default: begin
              state <= S_FIN;
            end
          endcase
        end
        S_LD1: begin
          if (dv_done) begin
            state    <= S_LD2;
          end
        end
        S_LD2: begin
          if (dv_done) begin
            state <= S_M1;
          end
        end
        S_M1: begin
          state <= S_M2;
        end
        S_M2: begin
          state <= S_M3;
        end
        S_M3: begin
          state <= S_SUM;
        end
        S_SUM: begin
          phase <= PH_RES;
          state <= S_RSTART;
        end
        S_FIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        mode_r <= f_mode;
        p_neg  <= f_aneg;
        p_mag  <= WW'(f_anum);
        p_den  <= WW'(f_aden);
        bi_neg <= f_bneg;
        bi_num <= f_bnum;
        bi_den <= f_bden;
        h_num  <= '0;
        h_den  <= '0;
        h_eq   <= 1'b0;
        h_err  <= f_zerr ? ERR_ZERO_DEN : ERR_OK;
      end
      S_RSTART: begin
        if (p_mag == '0) begin
          p_neg <= 1'b0;
          p_den <= WW'(1);
        end else begin
          x <= p_mag;
          y <= p_den;
        end
      end
      S_GCHK: begin
        if (y == '0) begin
          g      <= x;
          dv_den <= x;
          dv_num <= (phase == PH_LCM) ? WW'(a_den) : p_mag;
        end else begin
          dv_num <= x;
          dv_den <= y;
        end
      end
      S_GDIV: begin
        if (dv_done) begin
          x <= y;
          y <= dv_rem;
        end
      end
      S_RDIVM: begin
        if (dv_done) begin
          p_mag  <= dv_quo;
          dv_num <= p_den;
          dv_den <= g;
        end
      end
      S_RDIVD: begin
        if (dv_done) begin
          p_den <= dv_quo;
        end
      end
      S_RET: begin
        unique case (phase)
          PH_A: begin
            a_neg <= p_neg;
            a_mag <= p_mag[W-1:0];
            a_den <= p_den[W-1:0];
            if (mode_r != MODE_REDUCE) begin
              p_neg <= bi_neg;
              p_mag <= WW'(bi_num);
              p_den <= WW'(bi_den);
            end
          end
          PH_B: begin
            b_neg <= nb_neg;
            b_mag <= p_mag[W-1:0];
            b_den <= p_den[W-1:0];
            h_eq  <= (mode_r == MODE_COMPARE) && (a_neg == p_neg) &&
                     (a_mag == p_mag[W-1:0]) && (a_den == p_den[W-1:0]);
            x     <= WW'(a_den);
            y     <= p_den;
          end
          default: begin
            p_neg <= p_neg;
          end
        endcase
      end
      S_LD1: begin
        if (dv_done) begin
          qa     <= dv_quo[W-1:0];
          dv_num <= WW'(b_den);
          dv_den <= g;
        end
      end
      S_LD2: begin
        if (dv_done) begin
          qb <= dv_quo[W-1:0];
        end
      end
      S_M1: begin
        lcm <= mul_p;
      end
      S_M2: begin
        ma <= mul_p;
      end
      S_M3: begin
        mb <= mul_p;
      end
      S_SUM: begin
        p_den <= lcm;
        if (a_neg == b_neg) begin
          p_neg <= a_neg;
          p_mag <= ma + mb;
        end else if (ma >= mb) begin
          p_neg <= a_neg;
          p_mag <= ma - mb;
        end else begin
          p_neg <= b_neg;
          p_mag <= mb - ma;
        end
      end
      S_FIN: begin
        if (ovf) begin
          h_err <= ERR_OVERFLOW;
        end else begin
          h_num <= 32'($signed(sn[W-1:0]));
          h_den <= 31'(p_den[W-2:0]);
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          res_num    <= h_num;
          res_den    <= h_den;
          is_equal   <= h_eq;
          error_code <= h_err;
        end
      end
      default: begin
        h_eq <= h_eq;
      end
    endcase
  end

endmodule

[design/rational_add_sub_compare_top.sv]
// ----------------------------------------------------------------------------
// Rational add, subtract and compare unit
// One result item per input item, in order, exact to DATA_WIDTH bits.
// ----------------------------------------------------------------------------
// The back end works through each item with the serial divider, which resolves
// one quotient bit per cycle over 2*DATA_WIDTH bits. Every reduction costs one
// divide per Euclid step plus two divides; the sum adds one GCD, two divides,
// three multiplies and a final reduction. A two-entry queue lets the front end
// accept items while the back end works.
module rational_add_sub_compare_top #(
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic signed [31:0] b_num,
  input  logic signed [31:0] b_den,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] res_num,
  output logic [30:0]        res_den,
  output logic               is_equal,
  output logic [1:0]         error_code
);
  import rasc_pkg::*;

  q_ctl_t                q_ctl;
  logic                  q_pop;
  logic [1:0]            f_mode;
  logic                  f_zerr, f_aneg, f_bneg;
  logic [DATA_WIDTH-1:0] f_anum, f_aden, f_bnum, f_bden;

  rasc_front #(.W(DATA_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .a_num    (a_num),
    .a_den    (a_den),
    .b_num    (b_num),
    .b_den    (b_den),
    .q_ctl    (q_ctl),
    .q_pop    (q_pop),
    .f_mode   (f_mode),
    .f_zerr   (f_zerr),
    .f_aneg   (f_aneg),
    .f_anum   (f_anum),
    .f_aden   (f_aden),
    .f_bneg   (f_bneg),
    .f_bnum   (f_bnum),
    .f_bden   (f_bden)
  );

  rasc_back #(.W(DATA_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_ctl      (q_ctl),
    .q_pop      (q_pop),
    .f_mode     (f_mode),
    .f_zerr     (f_zerr),
    .f_aneg     (f_aneg),
    .f_anum     (f_anum),
    .f_aden     (f_aden),
    .f_bneg     (f_bneg),
    .f_bnum     (f_bnum),
    .f_bden     (f_bden),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res_num    (res_num),
    .res_den    (res_den),
    .is_equal   (is_equal),
    .error_code (error_code)
  );

endmodule

[design/rasc_chk.sv]
// ----------------------------------------------------------------------------
// Output checker
// Port-level checks on the result channel of the rational arithmetic unit.
// ----------------------------------------------------------------------------
module rasc_chk (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] res_num,
  input logic [30:0]        res_den,
  input logic               is_equal,
  input logic [1:0]         error_code
);
  import rasc_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Result item dropped while stalled.");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(res_num) && $stable(res_den) && $stable(error_code))
    else $error("Result item changed while stalled.");

  a_err_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_code != ERR_OK) |-> (res_num == 0) && (res_den == 0) && !is_equal)
    else $error("Error item carries data.");

  a_eq_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_equal |-> (res_num == 0) && (res_den == 0) && (error_code == ERR_OK))
    else $error("Compare item carries a fraction.");

endmodule

bind rational_add_sub_compare_top rasc_chk u_chk (.*);

[test/tb_rational_add_sub_compare_top.sv]
// ----------------------------------------------------------------------------
// Rational add, subtract and compare unit testbench
// Drives directed and random fraction items through the unit with random
// gaps on both channels, predicts each result with exact 64-bit arithmetic
// and checks every returned item field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rational_add_sub_compare_top;
  import rasc_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int N_RANDOM = 1430;

  typedef struct {
    logic [1:0] mode;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
    bit drain;
  } item_t;

  typedef struct {
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic is_equal;
    logic [1:0] error_code;
  } result_t;

  typedef struct {
    bit neg;
    longint unsigned mag;
    longint unsigned den;
  } frac_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] mode = MODE_REDUCE;
  logic signed [31:0] a_num = '0;
  logic signed [31:0] a_den = '0;
  logic signed [31:0] b_num = '0;
  logic signed [31:0] b_den = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] res_num;
  logic [30:0] res_den;
  logic is_equal;
  logic [1:0] error_code;

  item_t pending_items[$];
  result_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stimulus_done = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  bit drain_hold = 1'b0;
  bit in_taken = 1'b0;

  rational_add_sub_compare_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .out_valid(out_valid), .out_stall(out_stall),
    .res_num(res_num), .res_den(res_den), .is_equal(is_equal),
    .error_code(error_code)
  );

  always #1 clk = ~clk;

  function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_t lowest_terms(bit neg, longint unsigned mag, longint unsigned den);
    frac_t f;
    longint unsigned g;
    if (mag == 0) begin
      f.neg = 1'b0;
      f.mag = 0;
      f.den = 1;
    end else begin
      g = gcd64(mag, den);
      f.neg = neg;
      f.mag = mag / g;
      f.den = den / g;
    end
    return f;
  endfunction

  function automatic frac_t to_frac(logic [31:0] n, logic [31:0] d);
    longint unsigned nm;
    longint unsigned dm;
    nm = n[31] ? 64'(-$signed({32'hFFFFFFFF, n})) : 64'(n);
    dm = d[31] ? 64'(-$signed({32'hFFFFFFFF, d})) : 64'(d);
    return lowest_terms(n[31] != d[31], nm, dm);
  endfunction

  function automatic result_t rational_result(item_t it);
    result_t r;
    frac_t fa;
    frac_t fb;
    frac_t s;
    longint unsigned g;
    longint unsigned l;
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned lim;
    lim = 64'h80000000;
    r.res_num = '0;
    r.res_den = '0;
    r.is_equal = 1'b0;
    r.error_code = ERR_OK;
    if (it.a_den == 0 || (it.mode != MODE_REDUCE && it.b_den == 0)) begin
      r.error_code = ERR_ZERO_DEN;
      return r;
    end
    fa = to_frac(it.a_num, it.a_den);
    if (it.mode == MODE_REDUCE) begin
      s = fa;
    end else begin
      fb = to_frac(it.b_num, it.b_den);
      if (it.mode == MODE_COMPARE) begin
        r.is_equal = (fa.neg == fb.neg && fa.mag == fb.mag && fa.den == fb.den);
        return r;
      end
      if (it.mode == MODE_SUB && fb.mag != 0) fb.neg = !fb.neg;
      g = gcd64(fa.den, fb.den);
      l = (fa.den / g) * fb.den;
      ma = fa.mag * (l / fa.den);
      mb = fb.mag * (l / fb.den);
      if (fa.neg == fb.neg) s = lowest_terms(fa.neg, ma + mb, l);
      else if (ma >= mb) s = lowest_terms(fa.neg, ma - mb, l);
      else s = lowest_terms(fb.neg, mb - ma, l);
    end
    if (s.den > lim - 1 || (s.neg ? (s.mag > lim) : (s.mag > lim - 1))) begin
      r.error_code = ERR_OVERFLOW;
      return r;
    end
    r.res_num = s.neg ? 32'(-s.mag) : 32'(s.mag);
    r.res_den = 31'(s.den);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int gap_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 150);
  endfunction

  function automatic logic [31:0] rand_small();
    logic [31:0] v;
    v = $urandom_range(0, 200);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic [31:0] rand_field();
    int p;
    p = $urandom_range(0, 9);
    if (p < 4) return rand_small();
    if (p < 6) return $urandom();
    if (p < 8) return ($urandom_range(1, 5000) * $urandom_range(1, 5000))
                      * ($urandom_range(0, 1) ? -1 : 1);
    case ($urandom_range(0, 3))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 32'hFFFFFFFF;
      default: return 32'h00000001;
    endcase
  endfunction

  task automatic push_item(logic [1:0] m, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd, bit dr);
    item_t it;
    it.mode = m;
    it.a_num = an;
    it.a_den = ad;
    it.b_num = bn;
    it.b_den = bd;
    it.drain = dr;
    pending_items.push_back(it);
  endtask

  initial begin
    logic [31:0] k;
    logic [31:0] den;
    push_item(MODE_REDUCE, 6, -4, 0, 0, 0);
    push_item(MODE_REDUCE, 0, -7, 0, 0, 0);
    push_item(MODE_REDUCE, 5, 0, 1, 1, 0);
    push_item(MODE_ADD, 1, 2, 3, 0, 0);
    push_item(MODE_COMPARE, 1, 0, 1, 1, 0);
    push_item(MODE_REDUCE, 32'h80000000, 1, 0, 0, 0);
    push_item(MODE_REDUCE, 32'h80000000, -1, 0, 0, 0);
    push_item(MODE_REDUCE, 1, 32'h80000000, 0, 0, 0);
    push_item(MODE_REDUCE, 32'h80000000, 32'h80000000, 0, 0, 0);
    push_item(MODE_REDUCE, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0);
    push_item(MODE_ADD, 1, 3, 1, 6, 0);
    push_item(MODE_ADD, 32'h7FFFFFFF, 1, 1, 1, 0);
    push_item(MODE_ADD, 32'h80000000, 1, -1, 1, 0);
    push_item(MODE_ADD, 1, 32'h7FFFFFFF, 1, 32'h7FFFFFFE, 0);
    push_item(MODE_SUB, 1, 2, 1, 2, 0);
    push_item(MODE_SUB, 0, 5, 0, -9, 0);
    push_item(MODE_SUB, 32'h80000000, 1, 1, 1, 0);
    push_item(MODE_SUB, -3, 4, 5, -6, 0);
    push_item(MODE_COMPARE, 2, 4, -1, -2, 0);
    push_item(MODE_COMPARE, 0, 3, 0, -8, 0);
    push_item(MODE_COMPARE, 1, 2, -1, 2, 0);
    push_item(MODE_COMPARE, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1);
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        k = $urandom_range(1, 50);
        den = rand_small();
        push_item(2'($urandom_range(0, 3)), rand_field() * k, k * $urandom_range(1, 9),
                  rand_field(), den, i == N_RANDOM / 2);
      end else begin
        den = ($urandom_range(0, 30) == 0) ? 32'h0 : rand_field();
        push_item(2'($urandom_range(0, 3)), rand_field(), den, rand_field(),
                  ($urandom_range(0, 30) == 0) ? 32'h0 : rand_field(),
                  i == N_RANDOM / 2);
      end
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  always @(negedge clk) begin
    bit v;
    item_t it;
    if (!rst) begin
      v = in_valid && !in_taken;
      if (in_valid && in_taken) in_gap = gap_length();
      if (!v) begin
        if (drain_hold) begin
          if (expected_results.size() == 0) drain_hold = 1'b0;
        end else if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          mode <= it.mode;
          a_num <= it.a_num;
          a_den <= it.a_den;
          b_num <= it.b_num;
          b_den <= it.b_den;
          drain_hold = it.drain;
          expected_results.push_back(rational_result(it));
          v = 1'b1;
        end else begin
          stimulus_done = 1'b1;
        end
      end
      in_valid <= v;
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_gap = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
        out_stall <= (out_gap > 0);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      in_taken <= in_valid && !in_stall;
      idle_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ?
                     0 : idle_cycles + 1;
      if (out_valid && !out_stall) begin
        result_t w;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected item res_num", res_num, 32'h0);
        end else begin
          w = expected_results.pop_front();
          if (res_num !== w.res_num) report_mismatch("res_num", res_num, w.res_num);
          if (res_den !== w.res_den)
            report_mismatch("res_den", 32'(res_den), 32'(w.res_den));
          if (is_equal !== w.is_equal)
            report_mismatch("is_equal", 32'(is_equal), 32'(w.is_equal));
          if (error_code !== w.error_code)
            report_mismatch("error_code", 32'(error_code), 32'(w.error_code));
        end
      end
    end
  end

  initial begin
    wait (!rst);
    while (!(stimulus_done && expected_results.size() == 0 && !in_valid)) begin
      @(posedge clk);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
